// ----- rtl/alrl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package alrl_pkg;

	localparam int SLOTS  = 16;
	localparam int MAXRES = 16;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int STEP_W = $clog2(SLOTS + 1);
	localparam int CNT_W  = $clog2(MAXRES + 1);

	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 3'd0,
		OP_HEAD   = 3'd1,
		OP_INSERT = 3'd2,
		OP_DELETE = 3'd3,
		OP_SEARCH = 3'd4,
		OP_LIST   = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Input item payload, last declared field in the lowest bits.
	typedef struct packed {
		logic [3:0]  pad;
		logic [15:0] copies;
		logic [43:0] isbn_value;
		logic [63:0] author_tag;
		logic [63:0] title_tag;
		logic [31:0] anchor_number;
		logic [31:0] book_number;
		logic [3:0]  next_slot;
		logic [3:0]  slot_index;
	} in_data_t;

	// Result item payload, last declared field in the lowest bits.
	typedef struct packed {
		logic [3:0]  pad;
		logic [3:0]  link_out;
		logic [15:0] copies_out;
		logic [43:0] isbn_out;
		logic [63:0] author_out;
		logic [63:0] title_out;
		logic [31:0] key_out;
		logic [3:0]  slot_out;
	} out_data_t;

	localparam int IN_DATA_W  = $bits(in_data_t);
	localparam int OUT_DATA_W = $bits(out_data_t);

	// A slot index can be followed only if it is nonzero and inside the table.
	function automatic logic on_list(input logic [3:0] s);
		return (s != 4'd0) && (int'(s) < SLOTS);
	endfunction

	function automatic out_data_t blank_out(input logic [3:0] s);
		out_data_t r;
		r = '0;
		r.slot_out = s;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/array_linked_record_list.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake           Payload
// s_       in         s_tvalid/s_tready   s_tdata: command fields, s_tuser: operation
// m_       out        m_tvalid/m_tready   m_tdata: record, m_tuser: status, m_tlast
//
// A small sequencer walks the slot table one slot per cycle through a single
// record read port, a key comparator and a title comparator. Load, set head and
// unknown operations go from decode to the result; insert scans for the anchor,
// then for a free slot (the free-slot scan picks up where the anchor scan
// stops); delete, search and list follow the links. A stalled result output
// holds the sequencer. Reset clears the valid bits, links and head at once; the
// record store is not cleared. s_tready is high only while the sequencer is idle.

module array_linked_record_list (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// slot_index, next_slot, book_number, anchor_number, title_tag, author_tag,
	// isbn_value, copies, zero fill
	input  wire [alrl_pkg::IN_DATA_W-1:0]       s_tdata,
	// operation
	input  wire [alrl_pkg::OP_W-1:0]            s_tuser,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// slot_out, key_out, title_out, author_out, isbn_out, copies_out, link_out,
	// zero fill
	output logic [alrl_pkg::OUT_DATA_W-1:0]     m_tdata,
	// status
	output logic [alrl_pkg::STATUS_W-1:0]       m_tuser,
	output logic                                m_tlast
);
	import alrl_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_FIND,
		S_FREE,
		S_DEL,
		S_WALK,
		S_FINAL
	} state_t;

	typedef enum logic [1:0] {
		SRC_BLANK,
		SRC_MEM,
		SRC_PEND
	} src_t;

	localparam slot_t SLOT_LAST = slot_t'(SLOTS - 1);
	localparam slot_t SLOT_ONE  = slot_t'(1);

	state_t     state_q;
	src_t       src_q;
	op_t        op_q;
	in_data_t   in_q;
	status_t    res_status_q;
	logic [3:0] res_slot_q;
	logic       del_q;

	slot_t                  cur_q;
	slot_t                  prev_q;
	slot_t                  anc_q;
	slot_t                  head_q;
	logic [STEP_W-1:0]      steps_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   pend_q;
	out_data_t              pend_data_q;

	logic [SLOTS-1:0]       valid_q;
	slot_t                  link_q [SLOTS];

	logic [31:0]            key_mem    [SLOTS];
	logic [63:0]            title_mem  [SLOTS];
	logic [63:0]            author_mem [SLOTS];
	logic [43:0]            isbn_mem   [SLOTS];
	logic [15:0]            copies_mem [SLOTS];

	out_data_t              out_data_q;
	status_t                out_status_q;
	logic                   out_last_q;
	logic                   out_valid_q;

	logic                   out_free;
	logic                   mem_we;
	slot_t                  mem_wa;
	out_data_t              rd_data;
	logic                   cur_hit_key;
	logic                   cur_hit_walk;
	logic                   walk_end;
	logic                   del_end;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	assign out_free = !out_valid_q || m_tready;

	// Single read port of the record store, always at the cursor.
	always_comb begin
		rd_data            = '0;
		rd_data.slot_out   = 4'(cur_q);
		rd_data.key_out    = key_mem[cur_q];
		rd_data.title_out  = title_mem[cur_q];
		rd_data.author_out = author_mem[cur_q];
		rd_data.isbn_out   = isbn_mem[cur_q];
		rd_data.copies_out = copies_mem[cur_q];
		rd_data.link_out   = 4'(link_q[cur_q]);
	end

	assign cur_hit_key  = valid_q[cur_q] && (key_mem[cur_q] ==
		((state_q == S_FIND) ? in_q.anchor_number : in_q.book_number));
	assign cur_hit_walk = valid_q[cur_q] &&
		((op_q == OP_LIST) || (title_mem[cur_q] == in_q.title_tag));

	assign walk_end = (steps_q == STEP_W'(SLOTS)) || !on_list(4'(cur_q)) ||
		(cnt_q == CNT_W'(MAXRES));
	assign del_end  = (steps_q == STEP_W'(SLOTS)) || !on_list(4'(cur_q));

	assign mem_we = ((state_q == S_DECODE) && (op_q == OP_LOAD) &&
		on_list(in_q.slot_index)) || ((state_q == S_FREE) && !valid_q[cur_q]);
	assign mem_wa = (state_q == S_DECODE) ? slot_t'(in_q.slot_index) : cur_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_wa]    <= in_q.book_number;
			title_mem[mem_wa]  <= in_q.title_tag;
			author_mem[mem_wa] <= in_q.author_tag;
			isbn_mem[mem_wa]   <= in_q.isbn_value;
			copies_mem[mem_wa] <= in_q.copies;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			src_q        <= SRC_BLANK;
			op_q         <= OP_LOAD;
			in_q         <= '0;
			res_status_q <= ST_OK;
			res_slot_q   <= '0;
			del_q        <= 1'b0;
			cur_q        <= '0;
			prev_q       <= '0;
			anc_q        <= '0;
			head_q       <= '0;
			steps_q      <= '0;
			cnt_q        <= '0;
			pend_q       <= 1'b0;
			pend_data_q  <= '0;
			valid_q      <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				link_q[i] <= '0;
			end
			out_data_q   <= '0;
			out_status_q <= ST_OK;
			out_last_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= op_t'(s_tuser);
						in_q    <= in_data_t'(s_tdata);
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					src_q        <= SRC_BLANK;
					res_status_q <= ST_MISSING;
					res_slot_q   <= '0;
					del_q        <= 1'b0;
					steps_q      <= '0;
					cnt_q        <= '0;
					pend_q       <= 1'b0;
					prev_q       <= '0;
					state_q      <= S_FINAL;
					case (op_q)
						OP_LOAD: begin
							res_slot_q <= in_q.slot_index;
							cur_q      <= slot_t'(in_q.slot_index);
							if (on_list(in_q.slot_index)) begin
								valid_q[slot_t'(in_q.slot_index)] <= 1'b1;
								link_q[slot_t'(in_q.slot_index)]  <= slot_t'(in_q.next_slot);
								src_q <= SRC_MEM;
							end
						end
						OP_HEAD: begin
							res_slot_q <= in_q.slot_index;
							if (int'(in_q.slot_index) < SLOTS) begin
								head_q       <= slot_t'(in_q.slot_index);
								res_status_q <= ST_OK;
							end
						end
						OP_INSERT: begin
							cur_q   <= SLOT_ONE;
							state_q <= S_FIND;
						end
						OP_DELETE: begin
							cur_q   <= head_q;
							state_q <= S_DEL;
						end
						OP_SEARCH, OP_LIST: begin
							cur_q   <= head_q;
							state_q <= S_WALK;
						end
						default: begin
						end
					endcase
				end
				S_FIND: begin
					if (cur_hit_key) begin
						anc_q <= cur_q;
						if (cur_q == SLOT_LAST) begin
							res_status_q <= ST_FULL;
							state_q      <= S_FINAL;
						end else begin
							cur_q   <= cur_q + SLOT_ONE;
							state_q <= S_FREE;
						end
					end else if (cur_q == SLOT_LAST) begin
						state_q <= S_FINAL;
					end else begin
						cur_q <= cur_q + SLOT_ONE;
					end
				end
				S_FREE: begin
					if (!valid_q[cur_q]) begin
						valid_q[cur_q] <= 1'b1;
						link_q[cur_q]  <= link_q[anc_q];
						link_q[anc_q]  <= cur_q;
						src_q          <= SRC_MEM;
						state_q        <= S_FINAL;
					end else if (cur_q == SLOT_LAST) begin
						res_status_q <= ST_FULL;
						state_q      <= S_FINAL;
					end else begin
						cur_q <= cur_q + SLOT_ONE;
					end
				end
				S_DEL: begin
					if (del_end) begin
						state_q <= S_FINAL;
					end else if (cur_hit_key) begin
						// The unlink happens when the record leaves, so its old link is reported.
						src_q   <= SRC_MEM;
						del_q   <= 1'b1;
						state_q <= S_FINAL;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= link_q[cur_q];
						steps_q <= steps_q + STEP_W'(1);
					end
				end
				S_WALK: begin
					if (walk_end) begin
						src_q   <= pend_q ? SRC_PEND : SRC_BLANK;
						state_q <= S_FINAL;
					end else if (cur_hit_walk) begin
						// A match is held back until the next match or the walk's end, so the final one can carry tlast.
						if (!pend_q || out_free) begin
							if (pend_q) begin
								out_data_q   <= pend_data_q;
								out_status_q <= ST_OK;
								out_last_q   <= 1'b0;
								out_valid_q  <= 1'b1;
							end
							pend_data_q <= rd_data;
							pend_q      <= 1'b1;
							cnt_q       <= cnt_q + CNT_W'(1);
							cur_q       <= link_q[cur_q];
							steps_q     <= steps_q + STEP_W'(1);
						end
					end else begin
						cur_q   <= link_q[cur_q];
						steps_q <= steps_q + STEP_W'(1);
					end
				end
				S_FINAL: begin
					if (out_free) begin
						out_last_q  <= 1'b1;
						out_valid_q <= 1'b1;
						case (src_q)
							SRC_MEM: begin
								out_data_q   <= rd_data;
								out_status_q <= ST_OK;
							end
							SRC_PEND: begin
								out_data_q   <= pend_data_q;
								out_status_q <= ST_OK;
							end
							default: begin
								out_data_q   <= blank_out(res_slot_q);
								out_status_q <= res_status_q;
							end
						endcase
						if (del_q) begin
							if (steps_q == '0) begin
								head_q <= link_q[cur_q];
							end else begin
								link_q[prev_q] <= link_q[cur_q];
							end
							link_q[cur_q]  <= '0;
							valid_q[cur_q] <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_del_frees_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINAL && del_q && out_free) |=>
			(!valid_q[$past(cur_q)] && link_q[$past(cur_q)] == '0))
		else $error("deleted slot still valid or linked");

	a_insert_links_anchor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FREE && !valid_q[cur_q]) |=>
			(link_q[$past(anc_q)] == $past(cur_q) && valid_q[$past(cur_q)]))
		else $error("insert did not link new slot after anchor");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CNT_W'(MAXRES)) && (steps_q <= STEP_W'(SLOTS)))
		else $error("walk counters out of range");

	a_pend_only_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && pend_q && cur_hit_walk && !walk_end && !out_free) |=>
			(state_q == S_WALK && $stable(cur_q) && $stable(pend_data_q)))
		else $error("held-back result lost during output stall");

endmodule

`default_nettype wire
